// File: rtl/core/arbb_pkg.sv
package arbb_pkg;

  localparam int CoefW     = 32;             // Q16.16 coefficient and offset width
  localparam int FracBits  = 16;             // fraction bits of the coefficients
  localparam int InW       = 16;             // rectangle field width
  localparam int CoordBits = 17;             // corners live in [-2^17, 2^17-1]
  localparam int CoordW    = CoordBits + 1;  // signed corner width
  localparam int HW        = CoordW + 1;     // integer part of p - off
  localparam int DW        = HW + FracBits;  // p - off with fraction
  localparam int HiPW      = CoefW + HW;     // coef * integer part
  localparam int LoPW      = CoefW + FracBits + 1;  // coef * fraction part
  localparam int HiSW      = HiPW + 1;
  localparam int LoSW      = LoPW + 1;
  localparam int LoShW     = LoSW - FracBits;
  localparam int LoAddW    = LoShW + 1;
  localparam int PW        = HiSW + 1;       // mapped point, FracBits fraction bits
  localparam int FloorW    = PW - FracBits;
  localparam int DiffW     = FloorW + 1;
  localparam int OutW      = 32;
  localparam int ExtW      = 31;
  localparam int CfgIdxW   = 3;
  localparam int Latency   = 8;              // accept edge to result edge

  typedef enum logic [CfgIdxW-1:0] {
    RegM00     = 3'd0,
    RegM01     = 3'd1,
    RegM10     = 3'd2,
    RegM11     = 3'd3,
    RegOffX    = 3'd4,
    RegOffY    = 3'd5,
    RegInvMode = 3'd6
  } cfg_reg_t;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [HW-1:0]      hpart_t;
  typedef logic        [FracBits-1:0] lpart_t;
  typedef logic signed [PW-1:0]      point_t;

  typedef struct packed {
    logic signed [CoefW-1:0] m00;
    logic signed [CoefW-1:0] m01;
    logic signed [CoefW-1:0] m10;
    logic signed [CoefW-1:0] m11;
    logic signed [CoefW-1:0] off_x;
    logic signed [CoefW-1:0] off_y;
    logic                    inv;
  } arbb_cfg_t;

endpackage

// File: rtl/core/arbb_decomp.sv
module arbb_decomp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arbb_pkg::arbb_cfg_t   cfg,
  input  logic                  vld_i,
  input  arbb_pkg::coord_t      x_i [2],
  input  arbb_pkg::coord_t      y_i [2],
  output logic                  vld_o,
  output arbb_pkg::hpart_t      hx_o [2],
  output arbb_pkg::lpart_t      lx_o [2],
  output arbb_pkg::hpart_t      hy_o [2],
  output arbb_pkg::lpart_t      ly_o [2]
);

  logic signed [arbb_pkg::DW-1:0] dx [2];
  logic signed [arbb_pkg::DW-1:0] dy [2];
  arbb_pkg::hpart_t hx_nxt [2];
  arbb_pkg::hpart_t hy_nxt [2];
  arbb_pkg::lpart_t lx_nxt [2];
  arbb_pkg::lpart_t ly_nxt [2];
  logic vld_r;
  arbb_pkg::hpart_t hx_r [2];
  arbb_pkg::hpart_t hy_r [2];
  arbb_pkg::lpart_t lx_r [2];
  arbb_pkg::lpart_t ly_r [2];

  // inverse mode: split p - off into floor part and 16-bit fraction;
  // forward mode: integer part is p itself and the fraction is zero
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dx[i] = arbb_pkg::DW'($signed({x_i[i], {arbb_pkg::FracBits{1'b0}}}))
            - arbb_pkg::DW'($signed(cfg.off_x));
      dy[i] = arbb_pkg::DW'($signed({y_i[i], {arbb_pkg::FracBits{1'b0}}}))
            - arbb_pkg::DW'($signed(cfg.off_y));
      if (cfg.inv) begin
        hx_nxt[i] = dx[i][arbb_pkg::DW-1:arbb_pkg::FracBits];
        hy_nxt[i] = dy[i][arbb_pkg::DW-1:arbb_pkg::FracBits];
        lx_nxt[i] = dx[i][arbb_pkg::FracBits-1:0];
        ly_nxt[i] = dy[i][arbb_pkg::FracBits-1:0];
      end else begin
        hx_nxt[i] = arbb_pkg::HW'(x_i[i]);
        hy_nxt[i] = arbb_pkg::HW'(y_i[i]);
        lx_nxt[i] = '0;
        ly_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    hx_r <= hx_nxt;
    hy_r <= hy_nxt;
    lx_r <= lx_nxt;
    ly_r <= ly_nxt;
  end

  assign vld_o = vld_r;
  assign hx_o  = hx_r;
  assign hy_o  = hy_r;
  assign lx_o  = lx_r;
  assign ly_o  = ly_r;

endmodule

// File: rtl/core/arbb_xform.sv
module arbb_xform (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arbb_pkg::arbb_cfg_t  cfg,
  input  logic                 vld_i,
  input  arbb_pkg::hpart_t     hx_i [2],
  input  arbb_pkg::lpart_t     lx_i [2],
  input  arbb_pkg::hpart_t     hy_i [2],
  input  arbb_pkg::lpart_t     ly_i [2],
  output logic                 vld_o,
  output arbb_pkg::point_t     px_o [4],
  output arbb_pkg::point_t     py_o [4]
);

  // stage A: products (shared by the two corners on each edge)
  logic signed [arbb_pkg::HiPW-1:0] p00_nxt [2], p10_nxt [2], p01_nxt [2], p11_nxt [2];
  logic signed [arbb_pkg::LoPW-1:0] q00_nxt [2], q10_nxt [2], q01_nxt [2], q11_nxt [2];
  logic signed [arbb_pkg::HiPW-1:0] p00_r [2], p10_r [2], p01_r [2], p11_r [2];
  logic signed [arbb_pkg::LoPW-1:0] q00_r [2], q10_r [2], q01_r [2], q11_r [2];
  logic va_r;

  // stage B: per-corner sums
  logic signed [arbb_pkg::LoSW-1:0]   lsx [4], lsy [4];
  logic signed [arbb_pkg::HiSW-1:0]   hix_nxt [4], hiy_nxt [4];
  logic signed [arbb_pkg::LoAddW-1:0] lox_nxt [4], loy_nxt [4];
  logic signed [arbb_pkg::HiSW-1:0]   hix_r [4], hiy_r [4];
  logic signed [arbb_pkg::LoAddW-1:0] lox_r [4], loy_r [4];
  logic vb_r;

  // stage C: mapped corner
  arbb_pkg::point_t px_r [4], py_r [4];
  logic vc_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      p00_nxt[i] = arbb_pkg::HiPW'($signed(cfg.m00)) * arbb_pkg::HiPW'(hx_i[i]);
      p10_nxt[i] = arbb_pkg::HiPW'($signed(cfg.m10)) * arbb_pkg::HiPW'(hx_i[i]);
      p01_nxt[i] = arbb_pkg::HiPW'($signed(cfg.m01)) * arbb_pkg::HiPW'(hy_i[i]);
      p11_nxt[i] = arbb_pkg::HiPW'($signed(cfg.m11)) * arbb_pkg::HiPW'(hy_i[i]);
      q00_nxt[i] = arbb_pkg::LoPW'($signed(cfg.m00))
                 * arbb_pkg::LoPW'($signed({1'b0, lx_i[i]}));
      q10_nxt[i] = arbb_pkg::LoPW'($signed(cfg.m10))
                 * arbb_pkg::LoPW'($signed({1'b0, lx_i[i]}));
      q01_nxt[i] = arbb_pkg::LoPW'($signed(cfg.m01))
                 * arbb_pkg::LoPW'($signed({1'b0, ly_i[i]}));
      q11_nxt[i] = arbb_pkg::LoPW'($signed(cfg.m11))
                 * arbb_pkg::LoPW'($signed({1'b0, ly_i[i]}));
    end
  end

  // corner c uses x index c[0] and y index c[1]; the offset is added here
  // in forward mode, in inverse mode it was already taken off
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hix_nxt[c] = arbb_pkg::HiSW'(p00_r[c % 2]) + arbb_pkg::HiSW'(p01_r[c / 2]);
      hiy_nxt[c] = arbb_pkg::HiSW'(p10_r[c % 2]) + arbb_pkg::HiSW'(p11_r[c / 2]);
      lsx[c]     = arbb_pkg::LoSW'(q00_r[c % 2]) + arbb_pkg::LoSW'(q01_r[c / 2]);
      lsy[c]     = arbb_pkg::LoSW'(q10_r[c % 2]) + arbb_pkg::LoSW'(q11_r[c / 2]);
      lox_nxt[c] = arbb_pkg::LoAddW'($signed(lsx[c][arbb_pkg::LoSW-1:arbb_pkg::FracBits]))
                 + (cfg.inv ? '0 : arbb_pkg::LoAddW'($signed(cfg.off_x)));
      loy_nxt[c] = arbb_pkg::LoAddW'($signed(lsy[c][arbb_pkg::LoSW-1:arbb_pkg::FracBits]))
                 + (cfg.inv ? '0 : arbb_pkg::LoAddW'($signed(cfg.off_y)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= vld_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    p00_r <= p00_nxt;
    p10_r <= p10_nxt;
    p01_r <= p01_nxt;
    p11_r <= p11_nxt;
    q00_r <= q00_nxt;
    q10_r <= q10_nxt;
    q01_r <= q01_nxt;
    q11_r <= q11_nxt;
    hix_r <= hix_nxt;
    hiy_r <= hiy_nxt;
    lox_r <= lox_nxt;
    loy_r <= loy_nxt;
    for (int c = 0; c < 4; c++) begin
      px_r[c] <= arbb_pkg::PW'(hix_r[c]) + arbb_pkg::PW'(lox_r[c]);
      py_r[c] <= arbb_pkg::PW'(hiy_r[c]) + arbb_pkg::PW'(loy_r[c]);
    end
  end

  assign vld_o = vc_r;
  assign px_o  = px_r;
  assign py_o  = py_r;

endmodule

// File: rtl/core/arbb_box.sv
module arbb_box (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  arbb_pkg::point_t                 px_i [4],
  input  arbb_pkg::point_t                 py_i [4],
  output logic                             vld_o,
  output logic signed [arbb_pkg::OutW-1:0] left_o,
  output logic signed [arbb_pkg::OutW-1:0] top_o,
  output logic        [arbb_pkg::ExtW-1:0] width_o,
  output logic        [arbb_pkg::ExtW-1:0] height_o
);

  localparam logic [arbb_pkg::PW-1:0] CeilAdd =
    {{(arbb_pkg::PW-arbb_pkg::FracBits){1'b0}}, {arbb_pkg::FracBits{1'b1}}};

  function automatic logic signed [arbb_pkg::PW-1:0] pmin(
    input logic signed [arbb_pkg::PW-1:0] a,
    input logic signed [arbb_pkg::PW-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [arbb_pkg::PW-1:0] pmax(
    input logic signed [arbb_pkg::PW-1:0] a,
    input logic signed [arbb_pkg::PW-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  // saturate the floored value to 32-bit signed
  function automatic logic signed [arbb_pkg::OutW-1:0] sat_s32(
    input logic signed [arbb_pkg::FloorW-1:0] v
  );
    logic [arbb_pkg::FloorW-arbb_pkg::OutW:0] hi;
    hi = v[arbb_pkg::FloorW-1:arbb_pkg::OutW-1];
    if (hi == '0 || hi == '1) begin
      return v[arbb_pkg::OutW-1:0];
    end else if (v[arbb_pkg::FloorW-1]) begin
      return {1'b1, {(arbb_pkg::OutW-1){1'b0}}};
    end else begin
      return {1'b0, {(arbb_pkg::OutW-1){1'b1}}};
    end
  endfunction

  function automatic logic [arbb_pkg::ExtW-1:0] sat_ext(
    input logic signed [arbb_pkg::DiffW-1:0] d
  );
    if (d[arbb_pkg::DiffW-1]) begin
      return '0;
    end else if (d[arbb_pkg::DiffW-2:arbb_pkg::ExtW] != '0) begin
      return '1;
    end else begin
      return d[arbb_pkg::ExtW-1:0];
    end
  endfunction

  // stage D: min/max over the four corners
  arbb_pkg::point_t minx_r, maxx_r, miny_r, maxy_r;
  logic vd_r;

  // stage E: floored edges and ceiled far edges
  arbb_pkg::point_t cx, cy;
  logic signed [arbb_pkg::OutW-1:0]   left_r, top_r;
  logic signed [arbb_pkg::FloorW-1:0] cxe_r, cye_r;
  logic ve_r;

  // stage F: result word
  logic signed [arbb_pkg::DiffW-1:0] dw, dh;
  logic signed [arbb_pkg::OutW-1:0]  left_out_r, top_out_r;
  logic        [arbb_pkg::ExtW-1:0]  width_r, height_r;
  logic vf_r;

  always_comb begin
    cx = maxx_r + $signed(CeilAdd);
    cy = maxy_r + $signed(CeilAdd);
    dw = arbb_pkg::DiffW'(cxe_r) - arbb_pkg::DiffW'(left_r);
    dh = arbb_pkg::DiffW'(cye_r) - arbb_pkg::DiffW'(top_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      vd_r <= vld_i;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    minx_r <= pmin(pmin(px_i[0], px_i[1]), pmin(px_i[2], px_i[3]));
    maxx_r <= pmax(pmax(px_i[0], px_i[1]), pmax(px_i[2], px_i[3]));
    miny_r <= pmin(pmin(py_i[0], py_i[1]), pmin(py_i[2], py_i[3]));
    maxy_r <= pmax(pmax(py_i[0], py_i[1]), pmax(py_i[2], py_i[3]));
    left_r <= sat_s32($signed(minx_r[arbb_pkg::PW-1:arbb_pkg::FracBits]));
    top_r  <= sat_s32($signed(miny_r[arbb_pkg::PW-1:arbb_pkg::FracBits]));
    cxe_r  <= $signed(cx[arbb_pkg::PW-1:arbb_pkg::FracBits]);
    cye_r  <= $signed(cy[arbb_pkg::PW-1:arbb_pkg::FracBits]);
    left_out_r <= left_r;
    top_out_r  <= top_r;
    width_r    <= sat_ext(dw);
    height_r   <= sat_ext(dh);
  end

  assign vld_o    = vf_r;
  assign left_o   = left_out_r;
  assign top_o    = top_out_r;
  assign width_o  = width_r;
  assign height_o = height_r;

endmodule

// File: rtl/core/affine_rect_bounding_box_unit.sv
// channel | ports                                   | handshake
// input   | in_rect_left/top/width/height           | start && !busy
// result  | out_box_left/top/width/height           | out_strobe, one cycle, no stall
// config  | cfg_index, cfg_data                     | cfg_valid && cfg_ready
//
// One word accepted every cycle; busy stays low. Each result passes through the register
// chain input reg, decompose, multiply, corner sum, corner add, min/max, floor/ceil,
// width/height.
// Synchronous active-low reset clears the valid pipeline and loads the
// identity matrix, zero offset and forward mode.
module affine_rect_bounding_box_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [arbb_pkg::InW-1:0]     in_rect_left,
  input  logic signed [arbb_pkg::InW-1:0]     in_rect_top,
  input  logic        [arbb_pkg::InW-1:0]     in_rect_width,
  input  logic        [arbb_pkg::InW-1:0]     in_rect_height,
  output logic                                out_strobe,
  output logic signed [arbb_pkg::OutW-1:0]    out_box_left,
  output logic signed [arbb_pkg::OutW-1:0]    out_box_top,
  output logic        [arbb_pkg::ExtW-1:0]    out_box_width,
  output logic        [arbb_pkg::ExtW-1:0]    out_box_height,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [arbb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic        [arbb_pkg::CoefW-1:0]   cfg_data
);

  localparam logic [arbb_pkg::CoefW-1:0] One = {{(arbb_pkg::CoefW-arbb_pkg::FracBits-1){1'b0}},
                                                1'b1, {arbb_pkg::FracBits{1'b0}}};

  logic [arbb_pkg::CoefW-1:0] m00_r, m01_r, m10_r, m11_r, offx_r, offy_r;
  logic                       inv_r;
  arbb_pkg::arbb_cfg_t        cfg;

  logic             accept;
  logic             v1_r;
  arbb_pkg::coord_t x_r [2];
  arbb_pkg::coord_t y_r [2];
  arbb_pkg::coord_t x_nxt [2];
  arbb_pkg::coord_t y_nxt [2];

  logic             vdec;
  arbb_pkg::hpart_t hx [2], hy [2];
  arbb_pkg::lpart_t lx [2], ly [2];
  logic             vpt;
  arbb_pkg::point_t px [4], py [4];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r  <= One;
      m01_r  <= '0;
      m10_r  <= '0;
      m11_r  <= One;
      offx_r <= '0;
      offy_r <= '0;
      inv_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (arbb_pkg::cfg_reg_t'(cfg_index))
        arbb_pkg::RegM00:     m00_r  <= cfg_data;
        arbb_pkg::RegM01:     m01_r  <= cfg_data;
        arbb_pkg::RegM10:     m10_r  <= cfg_data;
        arbb_pkg::RegM11:     m11_r  <= cfg_data;
        arbb_pkg::RegOffX:    offx_r <= cfg_data;
        arbb_pkg::RegOffY:    offy_r <= cfg_data;
        arbb_pkg::RegInvMode: inv_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.m00   = $signed(m00_r);
    cfg.m01   = $signed(m01_r);
    cfg.m10   = $signed(m10_r);
    cfg.m11   = $signed(m11_r);
    cfg.off_x = $signed(offx_r);
    cfg.off_y = $signed(offy_r);
    cfg.inv   = inv_r;
  end

  // 16-bit left + 16-bit width always lands inside the 18-bit corner range
  always_comb begin
    x_nxt[0] = arbb_pkg::CoordW'(in_rect_left);
    y_nxt[0] = arbb_pkg::CoordW'(in_rect_top);
    x_nxt[1] = arbb_pkg::CoordW'(in_rect_left)
             + $signed({{(arbb_pkg::CoordW-arbb_pkg::InW){1'b0}}, in_rect_width});
    y_nxt[1] = arbb_pkg::CoordW'(in_rect_top)
             + $signed({{(arbb_pkg::CoordW-arbb_pkg::InW){1'b0}}, in_rect_height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  arbb_decomp u_decomp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .vld_i (v1_r),
    .x_i   (x_r),
    .y_i   (y_r),
    .vld_o (vdec),
    .hx_o  (hx),
    .lx_o  (lx),
    .hy_o  (hy),
    .ly_o  (ly)
  );

  arbb_xform u_xform (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .vld_i (vdec),
    .hx_i  (hx),
    .lx_i  (lx),
    .hy_i  (hy),
    .ly_i  (ly),
    .vld_o (vpt),
    .px_o  (px),
    .py_o  (py)
  );

  arbb_box u_box (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (vpt),
    .px_i     (px),
    .py_i     (py),
    .vld_o    (out_strobe),
    .left_o   (out_box_left),
    .top_o    (out_box_top),
    .width_o  (out_box_width),
    .height_o (out_box_height)
  );

endmodule

// File: rtl/core/arbb_checker.sv
module arbb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic cfg_ready
);

  // every accepted word produces its result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(arbb_pkg::Latency) out_strobe)
    else $error("accepted word produced no result");

  // no result without a matching accept
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, arbb_pkg::Latency))
    else $error("result without accepted word");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block stalled an input or config word");

endmodule

bind affine_rect_bounding_box_unit arbb_checker u_arbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .cfg_ready  (cfg_ready)
);

// File: dv/affine_rect_bounding_box_unit_tb.sv
`timescale 1ns / 100ps

module affine_rect_bounding_box_unit_tb;
  import arbb_pkg::*;

  localparam int     NumPhases   = 12;
  localparam int     PhaseItems  = 150;
  localparam int     StallLimit  = 2000;
  localparam longint Unit        = longint'(1) <<< FracBits;
  localparam longint BoxMax      = (longint'(1) <<< 31) - 1;
  localparam longint BoxMin      = -(longint'(1) <<< 31);
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;  // no register behind it

  typedef struct packed {
    logic signed [InW-1:0] left;
    logic signed [InW-1:0] top;
    logic        [InW-1:0] width;
    logic        [InW-1:0] height;
  } rect_t;

  typedef struct packed {
    logic signed [OutW-1:0] left;
    logic signed [OutW-1:0] top;
    logic        [ExtW-1:0] width;
    logic        [ExtW-1:0] height;
  } box_t;

  typedef enum {StepCfg, StepRect} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CoefW-1:0]     data;
    rect_t                rect;
    bit                   known;
    box_t                 box;
  } dir_step_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [InW-1:0]    in_rect_left;
  logic signed [InW-1:0]    in_rect_top;
  logic        [InW-1:0]    in_rect_width;
  logic        [InW-1:0]    in_rect_height;
  logic                     out_strobe;
  logic signed [OutW-1:0]   out_box_left;
  logic signed [OutW-1:0]   out_box_top;
  logic        [ExtW-1:0]   out_box_width;
  logic        [ExtW-1:0]   out_box_height;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic        [CfgIdxW-1:0] cfg_index;
  logic        [CoefW-1:0]  cfg_data;

  arbb_cfg_t  coef_regs;
  box_t       pending_boxes[$];
  box_t       want_box;
  dir_step_t  dir_steps[$];
  int         mismatches = 0;
  int         stall_cycles = 0;

  affine_rect_bounding_box_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_strobe     (out_strobe),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Bounding box of the four mapped corners under the current register copy.
  function automatic box_t bound_rect(input rect_t r);
    longint lim, x, y, px, py, minx, maxx, miny, maxy;
    longint dx, dy, hx, hy, lx, ly, left, top, w, h;
    longint c00, c01, c10, c11, ox, oy;
    longint xs[2];
    longint ys[2];
    box_t   b;
    c00 = $signed(coef_regs.m00);
    c01 = $signed(coef_regs.m01);
    c10 = $signed(coef_regs.m10);
    c11 = $signed(coef_regs.m11);
    ox  = $signed(coef_regs.off_x);
    oy  = $signed(coef_regs.off_y);
    lim = longint'(1) <<< CoordBits;
    xs[1] = clamp(longint'(r.left) + longint'(r.width), -lim, lim - 1);
    ys[1] = clamp(longint'(r.top) + longint'(r.height), -lim, lim - 1);
    xs[0] = clamp(longint'(r.left), -lim, lim - 1);
    ys[0] = clamp(longint'(r.top), -lim, lim - 1);
    minx = 0; maxx = 0; miny = 0; maxy = 0;
    for (int i = 0; i < 4; i++) begin
      x = xs[i & 1];
      y = ys[(i >> 1) & 1];
      if (!coef_regs.inv) begin
        px = c00 * x + c01 * y + ox;
        py = c10 * x + c11 * y + oy;
      end else begin
        // split p - off into integer and fraction, floor the fraction products
        dx = (x <<< FracBits) - ox;
        dy = (y <<< FracBits) - oy;
        hx = dx >>> FracBits;
        hy = dy >>> FracBits;
        lx = dx - (hx <<< FracBits);
        ly = dy - (hy <<< FracBits);
        px = c00 * hx + c01 * hy + ((c00 * lx + c01 * ly) >>> FracBits);
        py = c10 * hx + c11 * hy + ((c10 * lx + c11 * ly) >>> FracBits);
      end
      if (i == 0 || px < minx) minx = px;
      if (i == 0 || px > maxx) maxx = px;
      if (i == 0 || py < miny) miny = py;
      if (i == 0 || py > maxy) maxy = py;
    end
    left = clamp(minx >>> FracBits, BoxMin, BoxMax);
    top  = clamp(miny >>> FracBits, BoxMin, BoxMax);
    w    = clamp(((maxx + Unit - 1) >>> FracBits) - left, 0, BoxMax);
    h    = clamp(((maxy + Unit - 1) >>> FracBits) - top, 0, BoxMax);
    b.left   = left[OutW-1:0];
    b.top    = top[OutW-1:0];
    b.width  = w[ExtW-1:0];
    b.height = h[ExtW-1:0];
    return b;
  endfunction

  function automatic logic [CoefW-1:0] pick_coef(input int style);
    logic [CoefW-1:0] corner_vals[5];
    corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000,
                    32'hFFFF_0000};
    case (style)
      0: return corner_vals[$urandom_range(4)];
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;  // about +-4.0
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    dir_step_t s;
    s.kind  = StepCfg;
    s.idx   = idx;
    s.data  = data;
    s.rect  = '0;
    s.known = 1'b0;
    s.box   = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_rect(input logic signed [InW-1:0] l, input logic signed [InW-1:0] t,
                                   input logic [InW-1:0] w, input logic [InW-1:0] h);
    dir_step_t s;
    s.kind  = StepRect;
    s.idx   = '0;
    s.data  = '0;
    s.rect  = '{l, t, w, h};
    s.known = 1'b0;
    s.box   = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_known(input logic signed [InW-1:0] l, input logic signed [InW-1:0] t,
                                    input logic [InW-1:0] w, input logic [InW-1:0] h,
                                    input logic signed [OutW-1:0] bl,
                                    input logic signed [OutW-1:0] bt,
                                    input logic [ExtW-1:0] bw, input logic [ExtW-1:0] bh);
    dir_step_t s;
    s.kind  = StepRect;
    s.idx   = '0;
    s.data  = '0;
    s.rect  = '{l, t, w, h};
    s.known = 1'b1;
    s.box   = '{bl, bt, bw, bh};
    dir_steps.push_back(s);
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
  endtask

  // enters and leaves at a fresh clock edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegM00:     coef_regs.m00   = data;
      RegM01:     coef_regs.m01   = data;
      RegM10:     coef_regs.m10   = data;
      RegM11:     coef_regs.m11   = data;
      RegOffX:    coef_regs.off_x = data;
      RegOffY:    coef_regs.off_y = data;
      RegInvMode: coef_regs.inv   = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_rect(input rect_t r, input bit known, input box_t box, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_rect_left   <= r.left;
    in_rect_top    <= r.top;
    in_rect_width  <= r.width;
    in_rect_height <= r.height;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_boxes.push_back(known ? box : bound_rect(r));
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("affine_rect_bounding_box_unit_tb: FAIL");
        $finish;
      end
      if (out_strobe) begin
        if (pending_boxes.size() == 0) begin
          $error("result word with nothing expected: left %0d top %0d", out_box_left,
                 out_box_top);
          mismatches++;
        end else begin
          want_box = pending_boxes.pop_front();
          check_field("box_left", longint'($signed(want_box.left)),
                      longint'($signed(out_box_left)));
          check_field("box_top", longint'($signed(want_box.top)),
                      longint'($signed(out_box_top)));
          check_field("box_width", longint'(want_box.width), longint'(out_box_width));
          check_field("box_height", longint'(want_box.height), longint'(out_box_height));
        end
      end
    end
  end

  initial begin
    rect_t r;
    int    idle_pct;
    int    style;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_rect_left   = '0;
    in_rect_top    = '0;
    in_rect_width  = '0;
    in_rect_height = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    coef_regs      = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0};

    // identity after reset: box equals the rectangle
    add_known(0, 0, 0, 0, 0, 0, 0, 0);
    add_known(-32768, -32768, 0, 0, -32768, -32768, 0, 0);
    add_known(32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535);
    add_known(-32768, 32767, 65535, 0, -32768, 32767, 65535, 0);
    add_known(-1, -1, 1, 1, -1, -1, 1, 1);
    add_known(21845, -21846, 43690, 21845, 21845, -21846, 43690, 21845);
    // spare index is dropped, mode keeps bit 0 only
    add_cfg(RegSpare, 32'hDEAD_BEEF);
    add_cfg(RegInvMode, 32'hFFFF_FFFE);
    add_known(10, 20, 30, 40, 10, 20, 30, 40);
    // fractional matrix and offset, forward then inverse
    add_cfg(RegM00, 32'h0001_8000);
    add_cfg(RegM01, 32'hFFFF_8000);
    add_cfg(RegM10, 32'h0000_4000);
    add_cfg(RegM11, 32'hFFFE_0000);
    add_cfg(RegOffX, 32'h0000_8000);
    add_cfg(RegOffY, 32'hFFFF_4000);
    add_rect(-7, 3, 5, 9);
    add_rect(100, -200, 1, 1);
    add_rect(-32768, -32768, 65535, 65535);
    add_cfg(RegInvMode, 32'h8000_0003);
    add_rect(-7, 3, 5, 9);
    add_rect(100, -200, 1, 1);
    add_rect(-32768, -32768, 65535, 65535);
    // most negative coefficients: saturated edges
    add_cfg(RegM00, 32'h8000_0000);
    add_cfg(RegM01, 32'h8000_0000);
    add_cfg(RegM10, 32'h8000_0000);
    add_cfg(RegM11, 32'h8000_0000);
    add_cfg(RegOffX, 32'h0);
    add_cfg(RegOffY, 32'h0);
    add_cfg(RegInvMode, 32'h0);
    add_rect(32767, 32767, 65535, 65535);
    add_rect(-32768, -32768, 65535, 65535);
    // whole box below the range: left saturates, width clips to zero
    add_cfg(RegInvMode, 32'h1);
    add_cfg(RegOffX, 32'h8000_0000);
    add_cfg(RegOffY, 32'h8000_0000);
    add_known(32767, 32767, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    // most positive everything
    add_cfg(RegM00, 32'h7FFF_FFFF);
    add_cfg(RegM01, 32'h7FFF_FFFF);
    add_cfg(RegM10, 32'h7FFF_FFFF);
    add_cfg(RegM11, 32'h7FFF_FFFF);
    add_cfg(RegOffX, 32'h7FFF_FFFF);
    add_cfg(RegOffY, 32'h7FFF_FFFF);
    add_cfg(RegInvMode, 32'h0);
    add_rect(-32768, -32768, 65535, 65535);
    add_rect(32767, -32768, 65535, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == StepCfg) begin
        drain();
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      end else begin
        send_rect(dir_steps[i].rect, dir_steps[i].known, dir_steps[i].box, 0);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      style = ph % 3;
      case (ph % 4)
        1: idle_pct = 68;
        3: idle_pct = 20;
        default: idle_pct = 0;
      endcase
      drain();
      for (int k = RegM00; k <= RegOffY; k++) write_reg(CfgIdxW'(k), pick_coef(style));
      write_reg(RegInvMode, ($urandom() & ~32'h1) | CoefW'(ph & 1));
      write_reg(RegSpare, $urandom());
      for (int n = 0; n < PhaseItems; n++) begin
        r.left   = InW'($urandom());
        r.top    = InW'($urandom());
        r.width  = InW'($urandom());
        r.height = InW'($urandom());
        if ($urandom_range(3) == 0) r.width = InW'($urandom_range(15));
        if ($urandom_range(3) == 0) r.height = InW'($urandom_range(15));
        send_rect(r, 1'b0, '0, idle_pct);
      end
    end

    drain();
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("affine_rect_bounding_box_unit_tb: PASS");
    end else begin
      $display("affine_rect_bounding_box_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
